// ===== rtl/core/hgpl_pkg.sv =====
// ----------------------------------------------------------------------------
// hgpl_pkg
// Shared constants, types and tables of the hex grid point locator.
// ----------------------------------------------------------------------------
package hgpl_pkg;

  // Grid and coordinate sizes
  localparam int POINTS_PER_AXIS = 16;
  localparam int COORD_BITS      = 32;

  localparam int IDX_W  = $clog2(POINTS_PER_AXIS);
  localparam int ADDR_W = 3 * IDX_W;
  localparam int DEPTH  = POINTS_PER_AXIS * POINTS_PER_AXIS * POINTS_PER_AXIS;
  localparam int WORD_W = 3 * COORD_BITS;

  // Exact arithmetic widths: differences, normals, dot product
  localparam int DW = COORD_BITS + 1;
  localparam int NW = 2 * DW + 1;
  localparam int AW = NW + DW + 2;
  // Multiplier operand b is consumed in two halves
  localparam int HW = (DW + 1) / 2;

  // Corners (p0, p1, p2) of each face; corner bit 0 = i, 1 = j, 2 = k
  localparam logic [2:0] FACE_CORNER [6][3] = '{
    '{3'd0, 3'd2, 3'd4},
    '{3'd1, 3'd5, 3'd3},
    '{3'd0, 3'd4, 3'd1},
    '{3'd2, 3'd3, 3'd6},
    '{3'd0, 3'd1, 3'd2},
    '{3'd4, 3'd6, 3'd5}
  };
  localparam logic [2:0] LAST_FACE = 3'd5;

  // Multiply-accumulate request
  typedef struct packed {
    logic start;
    logic clr;   // start a fresh sum
    logic sub;   // subtract the product
  } mac_req_t;

  // Cells per axis from a 4-bit register field, capped to the grid
  function automatic logic [IDX_W-1:0] cap_count(input logic [3:0] n);
    logic [IDX_W-1:0] r;
    if (int'(n) > POINTS_PER_AXIS - 1) r = IDX_W'(POINTS_PER_AXIS - 1);
    else r = IDX_W'(n);
    return r;
  endfunction

endpackage

// ===== rtl/core/hgpl_ram.sv =====
// ----------------------------------------------------------------------------
// hgpl_ram
// Lattice point store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hgpl_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [hgpl_pkg::ADDR_W-1:0] waddr,
  input  logic [hgpl_pkg::WORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [hgpl_pkg::ADDR_W-1:0] raddr,
  output logic [hgpl_pkg::WORD_W-1:0] rdata
);
  import hgpl_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/hgpl_mac.sv =====
// ----------------------------------------------------------------------------
// hgpl_mac
// Exact signed multiply-accumulate, NW x DW bits; takes a new operation only when idle.
// ----------------------------------------------------------------------------
module hgpl_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hgpl_pkg::mac_req_t            req,
  input  logic signed [hgpl_pkg::NW-1:0] op_a,
  input  logic signed [hgpl_pkg::DW-1:0] op_b,
  output logic                          done,
  output logic signed [hgpl_pkg::AW-1:0] acc
);
  import hgpl_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_HI, PH_SUM} phase_t;

  phase_t               phase_r;
  logic [NW-1:0]        amag_r;
  logic [DW-1:0]        bmag_r;
  logic                 neg_r;
  logic                 clr_r;
  logic [NW+HW-1:0]     pp_r;
  logic [NW+HW-1:0]     lo_r;
  logic                 done_r;
  logic signed [AW-1:0] acc_r;

  logic [HW-1:0]        b_lo;
  logic [HW-1:0]        b_hi;
  logic [AW-1:0]        prod;
  logic signed [AW-1:0] base;

  assign b_lo = bmag_r[HW-1:0];
  assign b_hi = HW'(bmag_r >> HW);
  assign prod = AW'(lo_r) + (AW'(pp_r) << HW);
  assign base = clr_r ? '0 : acc_r;

  // operand capture, two partial products, signed accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        PH_IDLE: begin
          if (req.start) begin
            amag_r  <= op_a[NW-1] ? NW'(-op_a) : NW'(op_a);
            bmag_r  <= op_b[DW-1] ? DW'(-op_b) : DW'(op_b);
            neg_r   <= op_a[NW-1] ^ op_b[DW-1] ^ req.sub;
            clr_r   <= req.clr;
            phase_r <= PH_LO;
          end
        end
        PH_LO: begin
          pp_r    <= (NW+HW)'(amag_r * b_lo);
          phase_r <= PH_HI;
        end
        PH_HI: begin
          lo_r    <= pp_r;
          pp_r    <= (NW+HW)'(amag_r * b_hi);
          phase_r <= PH_SUM;
        end
        PH_SUM: begin
          acc_r   <= neg_r ? base - signed'(prod) : base + signed'(prod);
          done_r  <= 1'b1;
          phase_r <= PH_IDLE;
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

// ===== rtl/core/hex_grid_point_locator.sv =====
// ----------------------------------------------------------------------------
// hex_grid_point_locator
// Stores a structured hexahedral grid and finds the first cell holding a point.
// ----------------------------------------------------------------------------
//  channel | signals                                  | transfer
//  in      | in_valid/in_ready, operation, i/j/k, xyz | load or query
//  out     | out_valid/out_ready, found, cell_i/j/k   | one per query
//  cfg     | cfg_we, cfg_index, cfg_wdata             | write, no wait
//
// A load is written to the store on its input transfer. A query rejected by the box
// or by a zero cell count goes straight to the result. Otherwise each tested face
// reads its three corners, sets up the difference vectors and runs nine
// multiply-accumulates on the single shared multiply-accumulate unit.
// Reset is synchronous; the lattice store has no reset. A waiting result does
// not block new inputs until the next query finishes.
// ----------------------------------------------------------------------------
module hex_grid_point_locator (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [3:0]         in_lattice_i,
  input  logic [3:0]         in_lattice_j,
  input  logic [3:0]         in_lattice_k,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [3:0]         out_cell_i,
  output logic [3:0]         out_cell_j,
  output logic [3:0]         out_cell_k,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import hgpl_pkg::*;

  localparam logic [2:0] REG_CELL_COUNTS = 3'd0;
  localparam logic [2:0] REG_X_MIN       = 3'd1;
  localparam logic [2:0] REG_X_MAX       = 3'd2;
  localparam logic [2:0] REG_Y_MIN       = 3'd3;
  localparam logic [2:0] REG_Y_MAX       = 3'd4;
  localparam logic [2:0] REG_Z_MIN       = 3'd5;
  localparam logic [2:0] REG_Z_MAX       = 3'd6;

  localparam logic OP_LOAD = 1'b0;

  typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_VEC, ST_MAC, ST_DONE} state_t;

  // configuration registers
  logic [11:0]        cell_counts_r;
  logic signed [31:0] bx_min_r, bx_max_r, by_min_r, by_max_r, bz_min_r, bz_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_counts_r <= 12'hFFF;
      bx_min_r <= 32'sh8000_0000;
      bx_max_r <= 32'sh7FFF_FFFF;
      by_min_r <= 32'sh8000_0000;
      by_max_r <= 32'sh7FFF_FFFF;
      bz_min_r <= 32'sh8000_0000;
      bz_max_r <= 32'sh7FFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_COUNTS: cell_counts_r <= cfg_wdata[11:0];
        REG_X_MIN:       bx_min_r <= signed'(cfg_wdata);
        REG_X_MAX:       bx_max_r <= signed'(cfg_wdata);
        REG_Y_MIN:       by_min_r <= signed'(cfg_wdata);
        REG_Y_MAX:       by_max_r <= signed'(cfg_wdata);
        REG_Z_MIN:       bz_min_r <= signed'(cfg_wdata);
        REG_Z_MAX:       bz_max_r <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // control and datapath registers
  state_t                       state_r;
  logic signed [COORD_BITS-1:0] px_r, py_r, pz_r;
  logic [IDX_W-1:0]             ni_r, nj_r, nk_r;
  logic [IDX_W-1:0]             ci_r, cj_r, ck_r;
  logic [2:0]                   face_r;
  logic [1:0]                   rd_cnt_r;
  logic [3:0]                   step_r;
  logic                         mac_busy_r;
  logic signed [COORD_BITS-1:0] cx_r [3];
  logic signed [COORD_BITS-1:0] cy_r [3];
  logic signed [COORD_BITS-1:0] cz_r [3];
  logic signed [DW-1:0]         ux_r, uy_r, uz_r, vx_r, vy_r, vz_r, wx_r, wy_r, wz_r;
  logic signed [NW-1:0]         n1_r, n2_r, n3_r;
  logic                         res_found_r;
  logic [IDX_W-1:0]             res_i_r, res_j_r, res_k_r;
  logic                         out_valid_r;
  logic                         out_found_r;
  logic [IDX_W-1:0]             out_i_r, out_j_r, out_k_r;

  // input coordinates at internal width
  logic signed [COORD_BITS-1:0] px_in, py_in, pz_in;
  logic                         outside;
  logic [IDX_W-1:0]             cnt_i, cnt_j, cnt_k;
  logic                         in_xfer;
  logic                         res_load;

  assign px_in = COORD_BITS'(in_coord_x);
  assign py_in = COORD_BITS'(in_coord_y);
  assign pz_in = COORD_BITS'(in_coord_z);

  assign outside = (DW'(px_in) < DW'(bx_min_r)) || (DW'(px_in) > DW'(bx_max_r)) ||
                   (DW'(py_in) < DW'(by_min_r)) || (DW'(py_in) > DW'(by_max_r)) ||
                   (DW'(pz_in) < DW'(bz_min_r)) || (DW'(pz_in) > DW'(bz_max_r));

  assign cnt_i = cap_count(cell_counts_r[3:0]);
  assign cnt_j = cap_count(cell_counts_r[7:4]);
  assign cnt_k = cap_count(cell_counts_r[11:8]);

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // result moves to the output slot once the slot is free
  assign res_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // lattice store access
  logic              st_we, st_re;
  logic [ADDR_W-1:0] st_waddr, st_raddr;
  logic [WORD_W-1:0] st_wdata, st_rdata;
  logic [2:0]        corner;

  assign st_we    = in_xfer && (in_operation == OP_LOAD) &&
                    (int'(in_lattice_i) < POINTS_PER_AXIS) &&
                    (int'(in_lattice_j) < POINTS_PER_AXIS) &&
                    (int'(in_lattice_k) < POINTS_PER_AXIS);
  assign st_waddr = {IDX_W'(in_lattice_i), IDX_W'(in_lattice_j), IDX_W'(in_lattice_k)};
  assign st_wdata = {px_in, py_in, pz_in};

  assign corner   = (rd_cnt_r < 2'd3) ? FACE_CORNER[face_r][rd_cnt_r] : 3'd0;
  assign st_re    = (state_r == ST_RD) && (rd_cnt_r < 2'd3);
  assign st_raddr = {ci_r + IDX_W'(corner[0]), cj_r + IDX_W'(corner[1]),
                     ck_r + IDX_W'(corner[2])};

  hgpl_ram u_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // multiply-accumulate operand selection per step of a face
  mac_req_t             mac_req;
  logic signed [NW-1:0] mac_a;
  logic signed [DW-1:0] mac_b;
  logic                 mac_done;
  logic signed [AW-1:0] mac_acc;

  always_comb begin
    mac_req.start = (state_r == ST_MAC) && !mac_busy_r;
    mac_req.clr   = 1'b0;
    mac_req.sub   = 1'b0;
    mac_a         = '0;
    mac_b         = '0;
    case (step_r)
      4'd0: begin mac_a = NW'(uy_r); mac_b = vz_r; mac_req.clr = 1'b1; end
      4'd1: begin mac_a = NW'(vy_r); mac_b = uz_r; mac_req.sub = 1'b1; end
      4'd2: begin mac_a = NW'(uz_r); mac_b = vx_r; mac_req.clr = 1'b1; end
      4'd3: begin mac_a = NW'(vz_r); mac_b = ux_r; mac_req.sub = 1'b1; end
      4'd4: begin mac_a = NW'(ux_r); mac_b = vy_r; mac_req.clr = 1'b1; end
      4'd5: begin mac_a = NW'(vx_r); mac_b = uy_r; mac_req.sub = 1'b1; end
      4'd6: begin mac_a = n1_r; mac_b = wx_r; mac_req.clr = 1'b1; end
      4'd7: begin mac_a = n2_r; mac_b = wy_r; end
      4'd8: begin mac_a = n3_r; mac_b = wz_r; end
      default: ;
    endcase
  end

  hgpl_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  // next cell in k, j, i order
  logic k_more, j_more, i_more;
  assign k_more = ({1'b0, ck_r} + 1'b1) < {1'b0, nk_r};
  assign j_more = ({1'b0, cj_r} + 1'b1) < {1'b0, nj_r};
  assign i_more = ({1'b0, ci_r} + 1'b1) < {1'b0, ni_r};

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mac_busy_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rd_cnt_r    <= '0;
      step_r      <= '0;
      face_r      <= '0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer && (in_operation != OP_LOAD)) begin
            px_r <= px_in;
            py_r <= py_in;
            pz_r <= pz_in;
            ni_r <= cnt_i;
            nj_r <= cnt_j;
            nk_r <= cnt_k;
            ci_r <= '0;
            cj_r <= '0;
            ck_r <= '0;
            face_r      <= '0;
            rd_cnt_r    <= '0;
            res_found_r <= 1'b0;
            res_i_r     <= '0;
            res_j_r     <= '0;
            res_k_r     <= '0;
            if (outside || (cnt_i == '0) || (cnt_j == '0) || (cnt_k == '0)) begin
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_RD;
            end
          end
        end
        ST_RD: begin
          // read p0, p1, p2 of the face; data lands in the following cycle
          if (rd_cnt_r != 2'd0) begin
            cx_r[rd_cnt_r - 2'd1] <= st_rdata[WORD_W-1 -: COORD_BITS];
            cy_r[rd_cnt_r - 2'd1] <= st_rdata[2*COORD_BITS-1 -: COORD_BITS];
            cz_r[rd_cnt_r - 2'd1] <= st_rdata[COORD_BITS-1:0];
          end
          if (rd_cnt_r == 2'd3) begin
            state_r <= ST_VEC;
          end
          rd_cnt_r <= rd_cnt_r + 2'd1;
        end
        ST_VEC: begin
          ux_r <= DW'(cx_r[1]) - DW'(cx_r[0]);
          uy_r <= DW'(cy_r[1]) - DW'(cy_r[0]);
          uz_r <= DW'(cz_r[1]) - DW'(cz_r[0]);
          vx_r <= DW'(cx_r[2]) - DW'(cx_r[0]);
          vy_r <= DW'(cy_r[2]) - DW'(cy_r[0]);
          vz_r <= DW'(cz_r[2]) - DW'(cz_r[0]);
          wx_r <= DW'(px_r) - DW'(cx_r[0]);
          wy_r <= DW'(py_r) - DW'(cy_r[0]);
          wz_r <= DW'(pz_r) - DW'(cz_r[0]);
          step_r  <= '0;
          state_r <= ST_MAC;
        end
        ST_MAC: begin
          if (!mac_busy_r) begin
            mac_busy_r <= 1'b1;
          end else if (mac_done) begin
            mac_busy_r <= 1'b0;
            step_r     <= step_r + 4'd1;
            case (step_r)
              4'd1: n1_r <= NW'(mac_acc);
              4'd3: n2_r <= NW'(mac_acc);
              4'd5: n3_r <= NW'(mac_acc);
              default: ;
            endcase
            if (step_r == 4'd8) begin
              rd_cnt_r <= '0;
              if (mac_acc[AW-1]) begin
                // face rejects the point: move to the next cell
                face_r <= '0;
                if (k_more) begin
                  ck_r    <= ck_r + 1'b1;
                  state_r <= ST_RD;
                end else if (j_more) begin
                  ck_r    <= '0;
                  cj_r    <= cj_r + 1'b1;
                  state_r <= ST_RD;
                end else if (i_more) begin
                  ck_r    <= '0;
                  cj_r    <= '0;
                  ci_r    <= ci_r + 1'b1;
                  state_r <= ST_RD;
                end else begin
                  state_r <= ST_DONE;
                end
              end else if (face_r == LAST_FACE) begin
                res_found_r <= 1'b1;
                res_i_r     <= ci_r;
                res_j_r     <= cj_r;
                res_k_r     <= ck_r;
                state_r     <= ST_DONE;
              end else begin
                face_r  <= face_r + 3'd1;
                state_r <= ST_RD;
              end
            end
          end
        end
        ST_DONE: begin
          // hand the result over once the output slot is free
          if (res_load) begin
            out_found_r <= res_found_r;
            out_i_r     <= res_i_r;
            out_j_r     <= res_j_r;
            out_k_r     <= res_k_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_cell_i = 4'(out_i_r);
  assign out_cell_j = 4'(out_j_r);
  assign out_cell_k = 4'(out_k_r);

endmodule

// ===== dv/tb_hex_grid_point_locator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_grid_point_locator
// Loads small structured grids, sets cell counts and bounding boxes, and
// checks every query result against an exact-arithmetic point locator kept
// in the bench, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_hex_grid_point_locator;
  import hgpl_pkg::*;

  typedef enum logic {OP_LOAD = 1'b0, OP_QUERY = 1'b1} op_e;
  typedef enum logic [2:0] {
    REG_COUNTS = 3'd0, REG_X_MIN = 3'd1, REG_X_MAX = 3'd2, REG_Y_MIN = 3'd3,
    REG_Y_MAX = 3'd4, REG_Z_MIN = 3'd5, REG_Z_MAX = 3'd6
  } reg_e;

  typedef struct {
    logic       found;
    logic [3:0] ci;
    logic [3:0] cj;
    logic [3:0] ck;
  } hit_t;

  localparam int STALL_LIMIT = 50000;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;

  logic clk, rst_n;
  logic in_valid, in_ready, in_operation;
  logic [3:0] in_lattice_i, in_lattice_j, in_lattice_k;
  logic signed [31:0] in_coord_x, in_coord_y, in_coord_z;
  logic out_valid, out_ready, out_found;
  logic [3:0] out_cell_i, out_cell_j, out_cell_k;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;

  // bench copy of lattice and registers
  logic signed [31:0] grid_x [DEPTH];
  logic signed [31:0] grid_y [DEPTH];
  logic signed [31:0] grid_z [DEPTH];
  logic [11:0] cell_counts;
  logic signed [31:0] box [7];

  hit_t expected_hits [$];
  int errors;
  int idle_cycles;
  bit no_idle;

  hex_grid_point_locator uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // exact face test of one cell; 128-bit signed holds every product
  function automatic bit cell_contains(input int ci, input int cj, input int ck,
                                       input logic signed [31:0] px,
                                       input logic signed [31:0] py,
                                       input logic signed [31:0] pz);
    logic signed [127:0] x [8], y [8], z [8];
    logic signed [127:0] ux, uy, uz, vx, vy, vz, n1, n2, n3, dot, qx, qy, qz;
    int idx, p0, p1, p2;
    for (int c = 0; c < 8; c++) begin
      idx = ((ci + (c & 1)) * POINTS_PER_AXIS + cj + ((c >> 1) & 1)) * POINTS_PER_AXIS
            + ck + ((c >> 2) & 1);
      x[c] = grid_x[idx];
      y[c] = grid_y[idx];
      z[c] = grid_z[idx];
    end
    qx = px;
    qy = py;
    qz = pz;
    for (int f = 0; f < 6; f++) begin
      p0 = FACE_CORNER[f][0];
      p1 = FACE_CORNER[f][1];
      p2 = FACE_CORNER[f][2];
      ux = x[p1] - x[p0]; uy = y[p1] - y[p0]; uz = z[p1] - z[p0];
      vx = x[p2] - x[p0]; vy = y[p2] - y[p0]; vz = z[p2] - z[p0];
      n1 = uy * vz - vy * uz;
      n2 = uz * vx - vz * ux;
      n3 = ux * vy - vx * uy;
      dot = n1 * (qx - x[p0]) + n2 * (qy - y[p0]) + n3 * (qz - z[p0]);
      if (dot < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // first containing cell, k innermost
  function automatic hit_t locate_point(input logic signed [31:0] px,
                                        input logic signed [31:0] py,
                                        input logic signed [31:0] pz);
    hit_t h;
    int ni, nj, nk;
    h = '{1'b0, 4'd0, 4'd0, 4'd0};
    if (px < box[REG_X_MIN] || px > box[REG_X_MAX] || py < box[REG_Y_MIN] ||
        py > box[REG_Y_MAX] || pz < box[REG_Z_MIN] || pz > box[REG_Z_MAX])
      return h;
    ni = (cell_counts[3:0] > POINTS_PER_AXIS - 1) ? POINTS_PER_AXIS - 1 : cell_counts[3:0];
    nj = (cell_counts[7:4] > POINTS_PER_AXIS - 1) ? POINTS_PER_AXIS - 1 : cell_counts[7:4];
    nk = (cell_counts[11:8] > POINTS_PER_AXIS - 1) ? POINTS_PER_AXIS - 1 : cell_counts[11:8];
    for (int i = 0; i < ni; i++)
      for (int j = 0; j < nj; j++)
        for (int k = 0; k < nk; k++)
          if (cell_contains(i, j, k, px, py, pz)) begin
            h = '{1'b1, 4'(i), 4'(j), 4'(k)};
            return h;
          end
    return h;
  endfunction

  // one input transfer; valid stays high across back-to-back items
  task automatic send_item(input op_e op, input int li, input int lj, input int lk,
                           input logic signed [31:0] x, input logic signed [31:0] y,
                           input logic signed [31:0] z);
    int gap;
    int idx;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_lattice_i <= 4'(li);
    in_lattice_j <= 4'(lj);
    in_lattice_k <= 4'(lk);
    in_coord_x   <= x;
    in_coord_y   <= y;
    in_coord_z   <= z;
    do @(posedge clk); while (!in_ready);
    if (op == OP_LOAD) begin
      idx = (li * POINTS_PER_AXIS + lj) * POINTS_PER_AXIS + lk;
      grid_x[idx] = x;
      grid_y[idx] = y;
      grid_z[idx] = z;
    end else begin
      expected_hits.push_back(locate_point(x, y, z));
    end
  endtask

  // drain results so registers can change safely
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_e r, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (r == REG_COUNTS) cell_counts = v[11:0];
    else box[r] = v;
  endtask

  task automatic set_box(input logic signed [31:0] xl, input logic signed [31:0] xh,
                         input logic signed [31:0] yl, input logic signed [31:0] yh,
                         input logic signed [31:0] zl, input logic signed [31:0] zh);
    cfg_write(REG_X_MIN, xl);
    cfg_write(REG_X_MAX, xh);
    cfg_write(REG_Y_MIN, yl);
    cfg_write(REG_Y_MAX, yh);
    cfg_write(REG_Z_MIN, zl);
    cfg_write(REG_Z_MAX, zh);
  endtask

  // 3x3x3 lattice points: origin + index * pitch, plus random jitter
  task automatic load_grid(input longint org, input longint pitch, input longint jit);
    longint c [3];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++) begin
          c[0] = org + i * pitch;
          c[1] = org + j * pitch;
          c[2] = org + k * pitch;
          for (int a = 0; a < 3; a++)
            if (jit > 0) c[a] += longint'($urandom_range(0, 2 * jit)) - jit;
          send_item(OP_LOAD, i, j, k, 32'(c[0]), 32'(c[1]), 32'(c[2]));
        end
  endtask

  // grid spanning the whole coordinate range, no jitter
  task automatic test_extreme_grid();
    logic signed [31:0] pts [4];
    pts = '{CMIN, -32'sd715827883, 32'sd715827882, CMAX};
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        for (int k = 0; k < 4; k++)
          send_item(OP_LOAD, i, j, k, pts[i], pts[j], pts[k]);
    wait_idle();
    cfg_write(REG_COUNTS, 12'h333);
    send_item(OP_QUERY, 0, 0, 0, CMIN, CMIN, CMIN);
    send_item(OP_QUERY, 15, 15, 15, CMAX, CMAX, CMAX);
    send_item(OP_QUERY, 0, 0, 0, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_QUERY, 0, 0, 0, -32'sd1, -32'sd1, -32'sd1);
    send_item(OP_QUERY, 0, 0, 0, CMIN, CMAX, 32'sd0);
    send_item(OP_QUERY, 0, 0, 0, -32'sd1431655765, -32'sd1431655765, 32'sd1431655765);
  endtask

  // default counts 4095: first cell must hold the point so the scan stays short
  task automatic test_full_counts();
    wait_idle();
    cfg_write(REG_COUNTS, 12'hFFF);
    send_item(OP_QUERY, 0, 0, 0, -32'sd1431655765, -32'sd1431655765, -32'sd1431655765);
    send_item(OP_QUERY, 0, 0, 0, CMIN, CMIN, CMIN);
  endtask

  // inclusive limits, one step outside three of them, then the full range again
  task automatic test_bounds();
    logic signed [31:0] lo, hi;
    lo = -32'sd100000;
    hi = 32'sd200000;
    wait_idle();
    set_box(lo, hi, lo, hi, lo, hi);
    cfg_write(REG_COUNTS, 12'h333);
    send_item(OP_QUERY, 0, 0, 0, lo, lo, lo);
    send_item(OP_QUERY, 0, 0, 0, hi, hi, hi);
    send_item(OP_QUERY, 0, 0, 0, lo - 1, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 0, hi + 1, 0);
    send_item(OP_QUERY, 0, 0, 0, 0, 0, lo - 1);
    send_item(OP_QUERY, 0, 0, 0, CMAX, 0, 0);
    wait_idle();
    cfg_write(REG_COUNTS, 12'hFFF);
    send_item(OP_QUERY, 0, 0, 0, CMIN, 0, 0);
    wait_idle();
    set_box(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX);
  endtask

  // zero cells on one axis and on all axes, and a single cell
  task automatic test_counts();
    wait_idle();
    cfg_write(REG_COUNTS, 12'h303);
    send_item(OP_QUERY, 0, 0, 0, -32'sd1431655765, -32'sd1431655765, -32'sd1431655765);
    wait_idle();
    cfg_write(REG_COUNTS, 12'h000);
    send_item(OP_QUERY, 0, 0, 0, 0, 0, 0);
    wait_idle();
    cfg_write(REG_COUNTS, 12'h111);
    send_item(OP_QUERY, 0, 0, 0, -32'sd1431655765, -32'sd1431655765, -32'sd1431655765);
    send_item(OP_QUERY, 0, 0, 0, CMAX, CMAX, CMAX);
  endtask

  // collapsed cell: all corners equal, holds every point
  task automatic test_degenerate_cell();
    for (int c = 0; c < 8; c++)
      send_item(OP_LOAD, c & 1, (c >> 1) & 1, (c >> 2) & 1, 32'sd5, -32'sd7, 32'sd9);
    send_item(OP_QUERY, 0, 0, 0, CMAX, CMIN, 32'sd12345);
    send_item(OP_QUERY, 0, 0, 0, 32'sd5, -32'sd7, 32'sd9);
  endtask

  // random grids, counts and boxes; mostly queries near the grid
  task automatic test_random(input int phases);
    longint org, pitch, jit, span;
    int n;
    logic [3:0] cnt [3];
    for (int p = 0; p < phases; p++) begin
      wait_idle();
      no_idle = ($urandom_range(0, 3) == 0);
      pitch = longint'(1) << $urandom_range(12, 26);
      jit   = ($urandom_range(0, 1) == 1) ? pitch / 4 : 0;
      org   = longint'($urandom_range(0, 32'h7000_0000)) - 64'h3800_0000;
      load_grid(org, pitch, jit);
      wait_idle();
      for (int a = 0; a < 3; a++)
        cnt[a] = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 2));
      cfg_write(REG_COUNTS, {20'd0, cnt[2], cnt[1], cnt[0]});
      if ($urandom_range(0, 1) == 1) begin
        span = org + 2 * pitch;
        set_box(32'(org), 32'(span), 32'(org - pitch), 32'(span), 32'(org), 32'(span + pitch));
      end else begin
        set_box(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX);
      end
      n = 0;
      while (n < 12) begin
        case ($urandom_range(0, 9))
          0: send_item(OP_QUERY, $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom(), $urandom(), $urandom());
          1: send_item(OP_LOAD, $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 15),
                       32'(org + longint'($urandom_range(0, 3)) * pitch),
                       32'(org + longint'($urandom_range(0, 3)) * pitch),
                       32'(org + longint'($urandom_range(0, 3)) * pitch));
          default: send_item(OP_QUERY, 0, 0, 0,
                             32'(org - pitch / 2 + longint'($urandom_range(0, 4 * pitch))),
                             32'(org - pitch / 2 + longint'($urandom_range(0, 4 * pitch))),
                             32'(org - pitch / 2 + longint'($urandom_range(0, 4 * pitch))));
        endcase
        n++;
      end
    end
    no_idle = 1'b0;
  endtask

  // result side: random stalls, compare with oldest expectation
  initial begin
    int stall;
    hit_t e;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_hits.size() == 0) begin
        report_mismatch("result with no query pending");
      end else begin
        e = expected_hits.pop_front();
        if (out_found !== e.found)
          report_mismatch($sformatf("found %b exp %b", out_found, e.found));
        if (out_cell_i !== e.ci)
          report_mismatch($sformatf("cell_i %0d exp %0d", out_cell_i, e.ci));
        if (out_cell_j !== e.cj)
          report_mismatch($sformatf("cell_j %0d exp %0d", out_cell_j, e.cj));
        if (out_cell_k !== e.ck)
          report_mismatch($sformatf("cell_k %0d exp %0d", out_cell_k, e.ck));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_LOAD;
    in_lattice_i = '0;
    in_lattice_j = '0;
    in_lattice_k = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    cfg_we = 1'b0;
    cfg_index = REG_COUNTS;
    cfg_wdata = '0;
    for (int i = 0; i < DEPTH; i++) begin
      grid_x[i] = '0;
      grid_y[i] = '0;
      grid_z[i] = '0;
    end
    cell_counts = 12'hFFF;
    box[REG_COUNTS] = '0;
    box[REG_X_MIN] = CMIN; box[REG_X_MAX] = CMAX;
    box[REG_Y_MIN] = CMIN; box[REG_Y_MAX] = CMAX;
    box[REG_Z_MIN] = CMIN; box[REG_Z_MAX] = CMAX;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extreme_grid();
    test_full_counts();
    test_bounds();
    test_counts();
    test_degenerate_cell();
    test_random(1);

    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
